@@ rtl/wfm_pkg.sv @@
package wfm_pkg;

  // request kinds on the input channel
  localparam logic REQ_PATTERN  = 1'b0;
  localparam logic REQ_FILENAME = 1'b1;

  // wildcard bytes
  localparam logic [7:0] WILD_ONE = 8'h3F;  // '?'
  localparam logic [7:0] WILD_ANY = 8'h2A;  // '*'

  // ascii letter range folded to lower case
  localparam logic [7:0] UPPER_A   = 8'h41;
  localparam logic [7:0] UPPER_Z   = 8'h5A;
  localparam logic [7:0] CASE_STEP = 8'h20;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic       has_char;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic status;
  } out_item_t;

  // broadcast to every cell
  typedef struct packed {
    logic       pat_acc;    // pattern item accepted this cycle
    logic       fn_acc;     // filename item accepted this cycle
    logic       has_char;
    logic       fresh;      // active set reads as its restart value
    logic       case_fold;
    logic [7:0] fc;         // folded filename byte
    logic [7:0] wr_data;    // pattern byte to store
  } cell_ctl_t;

  // passed from a cell to its right neighbor
  typedef struct packed {
    logic step_carry;  // star closure of the set being stepped
    logic adv;         // position advances into the neighbor
    logic res_carry;   // star closure of the set being judged
  } cell_link_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
    if (en && c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_STEP;
    end
    return c;
  endfunction

endpackage

@@ rtl/wildcard_filename_matcher.sv @@
// wildcard filename matcher: glob match with '*' (any run) and '?' (one byte)
//
// input channel (in_valid / in_stall / in_item): pattern bytes (req_type 0)
// are loaded first, then filename bytes (req_type 1) stream in, one item per
// cycle while in_stall is low. is_last closes a pattern or a filename; has_char 0 marks an empty one.
// output channel (out_valid / out_stall / out_item): one item per filename,
// matched plus status (1 = pattern longer than PATTERN_MAX, never matches).
// cfg port (cfg_valid / cfg_ready / cfg_data): case_fold bit, always ready.
//
// throughput: one item per cycle while not stalled, pattern and filename alike. the pattern is
// held in a row of PATTERN_MAX cells, one byte and one active bit each; every
// filename byte steps all positions at once, and the star closure ripples
// through the row like a carry chain, which sets the cycle time.
// result path: the last filename item accepted sets the pending stage; the closed set
// is judged from there into the output register once the output is free.
// stall: a held result keeps out_item; a second result waiting behind it
// raises in_stall until the output frees up. reset leaves an empty pattern,
// case_fold 0 and only position zero active.
module wildcard_filename_matcher #(
  parameter int PATTERN_MAX = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wfm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output wfm_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import wfm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

  // pattern bookkeeping
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             open_r, open_nxt;
  logic [LEN_W-1:0] eff_len;
  logic             eff_ovf;
  logic             case_fold_r;

  // filename bookkeeping
  logic             fresh_r, fresh_nxt;
  logic             nonempty_r, nonempty_nxt;
  logic             tail_r, tail_nxt;
  logic             tail_eff;

  // result pipeline
  logic             pend_r;
  logic             pend_fail_r;
  logic             pend_status_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  logic             out_free;

  logic             acc;
  logic             pat_acc;
  logic             fn_acc;
  cell_ctl_t        ctl;
  cell_link_t       links [0:PATTERN_MAX];
  logic [PATTERN_MAX:0] closed_all;

  assign out_free = !out_valid_r || !out_stall;
  // a judged result cannot move on, so hold the active set
  assign in_stall = pend_r && !out_free;
  assign acc      = in_valid && !in_stall;
  assign pat_acc  = acc && (in_item.req_type == REQ_PATTERN);
  assign fn_acc   = acc && (in_item.req_type == REQ_FILENAME);

  assign cfg_ready = 1'b1;

  // a pattern item while no pattern is open starts over
  assign eff_len = open_r ? len_r : '0;
  assign eff_ovf = open_r ? ovf_r : 1'b0;

  always_comb begin
    ctl.pat_acc   = pat_acc;
    ctl.fn_acc    = fn_acc;
    ctl.has_char  = in_item.has_char;
    ctl.fresh     = fresh_r;
    ctl.case_fold = case_fold_r;
    ctl.fc        = fold_char(in_item.char_code, case_fold_r);
    ctl.wr_data   = in_item.char_code;
  end

  assign links[0] = '0;

  genvar p;
  generate
    for (p = 0; p < PATTERN_MAX; p++) begin : g_cell
      logic we;
      assign we = pat_acc && in_item.has_char && (eff_len == LEN_W'(p)) &&
                  (eff_len < LEN_MAX);
      wfm_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .seed       (p == 0),
        .we         (we),
        .valid      (LEN_W'(p) < len_r),
        .lnk_in     (links[p]),
        .lnk_out    (links[p+1]),
        .res_closed (closed_all[p])
      );
    end
  endgenerate

  // position past the last cell: whole pattern consumed
  assign closed_all[PATTERN_MAX] = tail_r | links[PATTERN_MAX].res_carry;
  assign tail_eff                = fresh_r ? 1'b0 : tail_r;

  always_comb begin
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    open_nxt     = open_r;
    fresh_nxt    = fresh_r;
    nonempty_nxt = nonempty_r;
    tail_nxt     = tail_r;
    priority if (pat_acc) begin
      len_nxt = eff_len;
      ovf_nxt = eff_ovf;
      if (in_item.has_char) begin
        if (eff_len < LEN_MAX) begin
          len_nxt = eff_len + LEN_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      open_nxt     = !in_item.is_last;
      fresh_nxt    = 1'b0;
      nonempty_nxt = 1'b0;
      tail_nxt     = 1'b0;
    end else if (fn_acc) begin
      open_nxt     = 1'b0;
      tail_nxt     = in_item.has_char ? links[PATTERN_MAX].adv : tail_eff;
      // after the last byte the raw set is judged once, then reads as restarted
      fresh_nxt    = in_item.is_last;
      nonempty_nxt = in_item.is_last ? 1'b0 : (nonempty_r | in_item.has_char);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      open_r      <= 1'b0;
      fresh_r     <= 1'b0;
      nonempty_r  <= 1'b0;
      tail_r      <= 1'b0;
      case_fold_r <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      ovf_r      <= ovf_nxt;
      open_r     <= open_nxt;
      fresh_r    <= fresh_nxt;
      nonempty_r <= nonempty_nxt;
      tail_r     <= tail_nxt;
      if (cfg_valid && cfg_ready) begin
        case_fold_r <= cfg_data;
      end
      // pend is never set while stalled: in_stall blocks the last item
      if (fn_acc && in_item.is_last) begin
        pend_r <= 1'b1;
      end else if (out_free) begin
        pend_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= pend_r;
      end
    end
  end

  // payload of the result pipeline
  always_ff @(posedge clk) begin
    if (fn_acc && in_item.is_last) begin
      // overflow, or an empty filename against a non-empty pattern
      pend_fail_r   <= ovf_r || ((len_r != '0) && !(nonempty_r || in_item.has_char));
      pend_status_r <= ovf_r;
    end
    if (pend_r && out_free) begin
      out_item_r.matched <= !pend_fail_r && closed_all[len_r];
      out_item_r.status  <= pend_status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/wfm_cell.sv @@
module wfm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  wfm_pkg::cell_ctl_t  ctl,
  input  logic                seed,   // active after restart (position zero only)
  input  logic                we,
  input  logic                valid,  // position lies inside the stored pattern
  input  wfm_pkg::cell_link_t lnk_in,
  output wfm_pkg::cell_link_t lnk_out,
  output logic                res_closed
);
  import wfm_pkg::*;

  logic [7:0] byte_r;
  logic       act_r;
  logic       act_nxt;
  logic       act_eff;
  logic       is_star;
  logic       hit;
  logic       sc;
  logic       rc;
  logic       stepped;

  always_ff @(posedge clk) begin
    if (we) begin
      byte_r <= ctl.wr_data;
    end
  end

  assign act_eff = ctl.fresh ? seed : act_r;
  assign is_star = valid && (byte_r == WILD_ANY);
  assign hit     = valid && (byte_r != WILD_ANY) &&
                   ((byte_r == WILD_ONE) || (fold_char(byte_r, ctl.case_fold) == ctl.fc));

  // closure and step on the live set
  assign sc                 = act_eff | lnk_in.step_carry;
  assign lnk_out.step_carry = sc & is_star;
  assign lnk_out.adv        = sc & hit;
  assign stepped            = (sc & is_star) | lnk_in.adv;

  // closure of the raw set, judged while a result is pending after the last filename item
  assign rc                = act_r | lnk_in.res_carry;
  assign lnk_out.res_carry = rc & is_star;
  assign res_closed        = rc;

  always_comb begin
    act_nxt = act_r;
    priority if (ctl.pat_acc) begin
      act_nxt = seed;
    end else if (ctl.fn_acc) begin
      act_nxt = ctl.has_char ? stepped : act_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= seed;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

@@ rtl/wfm_checker.sv @@
module wfm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input wfm_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input wfm_pkg::out_item_t out_item
);
  import wfm_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("held result item changed");

  // an overflowed pattern never reports a match
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status |-> !out_item.matched)
    else $error("match reported with overflow status");

  // a fresh result traces back to an accepted last filename item
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall &&
      (in_item.req_type == REQ_FILENAME) && in_item.is_last, 2))
    else $error("result item without a last filename item");

  // input stalls only behind a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

endmodule

bind wildcard_filename_matcher wfm_checker u_wfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
  import wfm_pkg::*;

  localparam int PAT_CAP = 64;

  typedef logic [7:0] char_q_t[$];

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  wildcard_filename_matcher #(
    .PATTERN_MAX(PAT_CAP)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------
  // glob predictor: its own copy of the pattern, the active position set
  // and the case_fold bit, stepped once per accepted item
  // ---------------------------------------------------------------------
  logic [7:0]      pat_bytes [PAT_CAP];
  int              pat_len   = 0;
  bit              pat_over  = 1'b0;
  bit              pat_open  = 1'b0;
  bit              name_seen = 1'b0;
  bit              fold_en   = 1'b0;
  bit [PAT_CAP:0]  live      = 1;

  // verdicts still owed by the block, oldest first
  out_item_t verdict_q[$];

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int matches_seen = 0;
  int cfg_writes   = 0;

  // idling controls; stall_on and hold_cycles are shared with the receiver process
  bit gaps_on     = 1'b1;
  bit stall_on    = 1'b1;
  int hold_cycles = 0;

  function automatic logic [7:0] fold_letter(input logic [7:0] c);
    if (fold_en && c >= UPPER_A && c <= UPPER_Z) begin
      return c | CASE_STEP;
    end
    return c;
  endfunction

  // every live position sitting on a star also enables the one after it;
  // ascending order lets a run of stars ripple through in one pass
  function automatic bit [PAT_CAP:0] star_reach(input bit [PAT_CAP:0] s);
    for (int p = 0; p < pat_len; p++) begin
      if (s[p] && pat_bytes[p] == WILD_ANY) begin
        s[p+1] = 1'b1;
      end
    end
    return s;
  endfunction

  function automatic void restart_name();
    live      = 1;
    name_seen = 1'b0;
  endfunction

  // returns 1 when the item produces a verdict
  function automatic bit apply_item(input in_item_t it, output out_item_t verdict);
    bit [PAT_CAP:0] cur;
    bit [PAT_CAP:0] nxt;
    verdict = '0;
    if (it.req_type == REQ_PATTERN) begin
      // first byte of a new pattern wipes the old one
      if (!pat_open) begin
        pat_len  = 0;
        pat_over = 1'b0;
      end
      if (it.has_char) begin
        if (pat_len < PAT_CAP) begin
          pat_bytes[pat_len] = it.char_code;
          pat_len++;
        end else begin
          pat_over = 1'b1;
        end
      end
      pat_open = !it.is_last;
      restart_name();
      return 1'b0;
    end
    // a filename byte closes whatever pattern is open
    pat_open = 1'b0;
    if (it.has_char) begin
      cur = star_reach(live);
      nxt = '0;
      for (int p = 0; p < pat_len; p++) begin
        if (cur[p]) begin
          if (pat_bytes[p] == WILD_ANY) begin
            nxt[p] = 1'b1;
          end else if (pat_bytes[p] == WILD_ONE ||
                       fold_letter(pat_bytes[p]) == fold_letter(it.char_code)) begin
            nxt[p+1] = 1'b1;
          end
        end
      end
      live      = nxt;
      name_seen = 1'b1;
    end
    if (!it.is_last) begin
      return 1'b0;
    end
    // empty filename never matches a non-empty pattern, not even "*"
    cur             = star_reach(live);
    verdict.status  = pat_over;
    verdict.matched = !pat_over && !(pat_len > 0 && !name_seen) && cur[pat_len];
    restart_name();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------
  function automatic in_item_t make_item(input logic req, input logic [7:0] c,
                                         input logic has, input logic last);
    in_item_t it;
    it.req_type  = req;
    it.char_code = c;
    it.has_char  = has;
    it.is_last   = last;
    return it;
  endfunction

  // offer one item, hold it until taken, then maybe idle for a burst
  task automatic send_item(input in_item_t it);
    out_item_t verdict;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    if (apply_item(it, verdict)) begin
      verdict_q = {verdict_q, verdict};
    end
    items_sent++;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // a whole pattern or filename; an empty one is a single no-byte item.
  // with close = 0 the last item leaves the pattern open
  task automatic send_string(input logic req, input char_q_t s, input bit close);
    if (s.size() == 0) begin
      send_item(make_item(req, 8'($urandom_range(0, 255)), 1'b0, close));
    end else begin
      for (int i = 0; i < s.size(); i++) begin
        send_item(make_item(req, s[i], 1'b1, close && i == s.size() - 1));
      end
    end
  endtask

  // sender pauses until every owed verdict is in and the block has settled
  task automatic drain_block();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_case_fold(input logic v);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fold_en = v;
    cfg_writes++;
  endtask

  function automatic char_q_t str_to_chars(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) begin
      q = {q, s[i]};
    end
    return q;
  endfunction

  // letters and the bytes just outside both letter ranges
  function automatic logic [7:0] letter_ish();
    string pool;
    pool     = "aabbABAB@[_{zZ";
    pool[10] = 8'h60;  // grave accent, just below 'a'
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_pat_char();
    int r;
    r = $urandom_range(0, 11);
    if (r < 2) begin
      return WILD_ANY;
    end else if (r == 2) begin
      return WILD_ONE;
    end else if (r < 10) begin
      return letter_ish();
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly short patterns, a few long ones and a few past capacity
  function automatic char_q_t rand_pattern();
    char_q_t q;
    int      len;
    int      r;
    r = $urandom_range(0, 39);
    if (r == 0) begin
      len = 0;
    end else if (r < 34) begin
      len = $urandom_range(1, 8);
    end else if (r < 38) begin
      len = $urandom_range(9, 40);
    end else begin
      len = $urandom_range(60, 70);
    end
    repeat (len) q = {q, rand_pat_char()};
    return q;
  endfunction

  function automatic char_q_t rand_chars();
    char_q_t q;
    repeat ($urandom_range(0, 10)) begin
      q = {q, ($urandom_range(0, 1) ? letter_ish() : 8'($urandom_range(0, 255)))};
    end
    return q;
  endfunction

  // a filename built to fit the pattern, then sometimes broken by one edit
  function automatic char_q_t name_for(input char_q_t pat);
    char_q_t    q;
    logic [7:0] c;
    int         idx;
    foreach (pat[i]) begin
      c = pat[i];
      if (c == WILD_ANY) begin
        repeat ($urandom_range(0, 3)) q = {q, letter_ish()};
      end else if (c == WILD_ONE) begin
        q = {q, 8'($urandom_range(0, 255))};
      end else if (((c | CASE_STEP) >= "a") && ((c | CASE_STEP) <= "z") &&
                   $urandom_range(0, 2) == 0) begin
        q = {q, c ^ CASE_STEP};
      end else begin
        q = {q, c};
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      idx = (q.size() == 0) ? 0 : $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 2))
        0: if (q.size() != 0) q[idx] = letter_ish();
        1: if (q.size() != 0) q.delete(idx);
        default: q.insert(idx, letter_ish());
      endcase
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------
  // receiver side: random stall bursts, plus one long hold on request;
  // the hold is counted here so the sender can keep pushing meanwhile
  // ---------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker: every taken verdict against the oldest one owed
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got matched %0b status %0b",
                 $time, out_item.matched, out_item.status);
      end else begin
        want = verdict_q.pop_front();
        if (want.matched) begin
          matches_seen++;
        end
        if (out_item.matched !== want.matched) begin
          errors++;
          $display("%0t: matched mismatch, expected %0b got %0b",
                   $time, want.matched, out_item.matched);
        end
        if (out_item.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0b got %0b",
                   $time, want.status, out_item.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // empty pattern against empty and one-byte names, star against empty and two-byte names
  task automatic test_empty_strings();
    char_q_t none;
    send_string(REQ_FILENAME, none, 1'b1);                  // reset pattern, empty name
    send_string(REQ_FILENAME, str_to_chars("x"), 1'b1);     // empty pattern, one byte
    send_string(REQ_PATTERN, none, 1'b1);
    send_string(REQ_FILENAME, none, 1'b1);
    send_string(REQ_PATTERN, str_to_chars("*"), 1'b1);
    send_string(REQ_FILENAME, none, 1'b1);                  // star still needs a byte
    send_string(REQ_FILENAME, {8'h00, 8'hFF}, 1'b1);
  endtask

  // question mark, star, and a filename arriving while a pattern is open
  task automatic test_wildcards();
    send_string(REQ_PATTERN, str_to_chars("a?*c"), 1'b1);
    send_string(REQ_FILENAME, str_to_chars("abc"), 1'b1);
    send_string(REQ_FILENAME, str_to_chars("ab"), 1'b1);
    send_string(REQ_PATTERN, {8'hFF}, 1'b0);
    send_string(REQ_FILENAME, {8'hFF}, 1'b1);
    send_string(REQ_FILENAME, {8'h00}, 1'b1);
  endtask

  // letters fold only inside A-Z, brackets and braces stay apart
  task automatic test_case_fold();
    write_case_fold(1'b1);
    send_string(REQ_PATTERN, str_to_chars("aZ["), 1'b1);
    send_string(REQ_FILENAME, str_to_chars("Az["), 1'b1);
    send_string(REQ_FILENAME, str_to_chars("Az{"), 1'b1);
    write_case_fold(1'b0);
    send_string(REQ_FILENAME, str_to_chars("Az["), 1'b1);
    send_string(REQ_FILENAME, str_to_chars("aZ["), 1'b1);
  endtask

  // a pattern that just fills the store, then one byte too many
  task automatic test_pattern_overflow();
    char_q_t pat;
    char_q_t name;
    repeat (PAT_CAP - 1) pat = {pat, 8'h61};
    pat  = {pat, WILD_ANY};
    name = pat;
    name[PAT_CAP-1] = "z";
    name = {name, 8'h7A};
    send_string(REQ_PATTERN, pat, 1'b1);
    send_string(REQ_FILENAME, name, 1'b1);
    pat.delete();
    repeat (PAT_CAP + 1) pat = {pat, WILD_ONE};
    send_string(REQ_PATTERN, pat, 1'b1);
    send_string(REQ_FILENAME, rand_chars(), 1'b1);
  endtask

  // long receiver hold while short names keep coming, so the block backs up
  task automatic test_output_backpressure();
    char_q_t none;
    send_string(REQ_PATTERN, str_to_chars("?*"), 1'b1);
    gaps_on     = 1'b0;
    hold_cycles = 300;
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) begin
        send_string(REQ_FILENAME, none, 1'b1);
      end else begin
        send_string(REQ_FILENAME, {8'($urandom_range(0, 255))}, 1'b1);
      end
    end
    gaps_on = 1'b1;
    drain_block();
  endtask

  // patterns with fitting, broken and random names, some noise in between;
  // case_fold is rewritten at random now and then, the tail runs with no idling at all
  task automatic test_random_traffic(input int target);
    char_q_t pat;
    char_q_t name;
    char_q_t head;
    int      end_at;
    int      quiet_from;
    int      next_cfg;
    int      cut;
    end_at     = items_sent + target;
    quiet_from = items_sent + target * 4 / 5;
    next_cfg   = items_sent + 150;
    while (items_sent < end_at) begin
      if (items_sent >= quiet_from) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end
      if (items_sent >= next_cfg) begin
        write_case_fold(1'($urandom_range(0, 1)));
        next_cfg += 150;
      end
      pat = rand_pattern();
      case ($urandom_range(0, 9))
        0: begin
          // no-byte item in the middle of a pattern
          cut  = $urandom_range(0, pat.size());
          head = pat[0:cut-1];
          if (cut > 0) send_string(REQ_PATTERN, head, 1'b0);
          send_item(make_item(REQ_PATTERN, 8'($urandom_range(0, 255)), 1'b0, 1'b0));
          send_string(REQ_PATTERN, pat[cut:$], 1'b1);
        end
        // left open, the first filename byte closes it
        1: send_string(REQ_PATTERN, pat, 1'b0);
        default: send_string(REQ_PATTERN, pat, 1'b1);
      endcase
      repeat ($urandom_range(1, 4)) begin
        if (pat.size() > PAT_CAP || $urandom_range(0, 4) == 0) begin
          name = rand_chars();
        end else begin
          name = name_for(pat);
        end
        if ($urandom_range(0, 9) == 0) begin
          send_item(make_item(REQ_FILENAME, 8'($urandom_range(0, 255)), 1'b0, 1'b0));
        end
        send_string(REQ_FILENAME, name, 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_strings();
    test_wildcards();
    test_case_fold();
    test_pattern_overflow();
    test_output_backpressure();
    test_random_traffic(1000);

    // everything owed must arrive, then a few cycles for stray results
    drain_block();
    repeat (8) @(posedge clk);

    $display("sent %0d items, checked %0d results (%0d matches), %0d case_fold writes",
             items_sent, results_seen, matches_seen, cfg_writes);
    $display("covered empty strings, wildcards, case folding, overflow and backpressure");
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d results still owed", verdict_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
